[rtl/ugli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugli_pkg: shared types and constants for the uniform grid interpolator
// Action, status and register codes, FSM states and divider widths.
// ----------------------------------------------------------------------------
package ugli_pkg;

   localparam int DEPTH_DEFAULT = 256;

   // action codes
   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_EVAL   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_ORIGIN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP     = 1'b1;

   // divider: {|d|, 16'b0} / step
   localparam int DIV_NUM_W = 49;
   localparam int DIV_DEN_W = 31;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
      logic                 rem_nz;
   } div_result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_ADJ,
      ST_CLAMP,
      ST_READ_A,
      ST_READ_B,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

[rtl/ugli_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugli_div: radix-2 restoring divider
// One quotient bit per cycle; quotient and remainder flag hold until restart.
// ----------------------------------------------------------------------------
module ugli_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ugli_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [ugli_pkg::DIV_DEN_W-1:0] divisor,
   output ugli_pkg::div_result_type      result
);
   import ugli_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LastCnt = DIV_CNT_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;

   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W+1:0] trial;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = ~trial[DIV_DEN_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LastCnt;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;
   assign result.rem_nz   = (rem_ff != '0);

endmodule

[rtl/ugli_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugli_table: sample memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ugli_table #(
   parameter int DEPTH = ugli_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);
   import ugli_pkg::*;

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/uniform_grid_linear_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_linear_interpolator: Q16.16 lookup table with linear interp
// Appends samples on a uniform grid, evaluates y(x) between neighbors,
// clears the table on request.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                 payload
//   req      in   req_valid / req_stall      req_action, req_sample_value,
//                                            req_query_x
//   rsp      out  rsp_valid / rsp_stall      rsp_result_value, rsp_status
//   csr      in   csr_write_enable           csr_index, csr_write_data
//
// Append, clear, the unused action code and evaluate on an empty table go
// straight to the done state. Evaluate runs the 49-step radix-2 divider
// that forms (x - origin) * 65536 / step, then the two table reads.
// Synchronous active-high reset empties the table (fill count only), sets
// origin to 0 and step to 1.0. No clearing pass.
// One item in flight; the result register lets the next transfer in while
// a result waits on rsp_stall.
// ----------------------------------------------------------------------------
module uniform_grid_linear_interpolator #(
   parameter int DEPTH = ugli_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic signed [31:0]                req_sample_value,
   input  logic signed [31:0]                req_query_x,
   // response
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_result_value,
   output logic [1:0]                        rsp_status,
   // config
   input  logic                              csr_write_enable,
   input  logic [ugli_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_write_data
);
   import ugli_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = 34;                          // grid index width
   localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

   // ---- state ----
   state_type             state_ff, state_in;
   logic signed [31:0]    x_origin_ff;
   logic [30:0]           step_ff;
   logic [CW-1:0]         fill_count_ff;

   logic signed [32:0]    d_ff;                     // query_x - x_origin
   logic signed [49:0]    p_ff;                     // floor(d*65536/step)
   logic [AW-1:0]         addr_a_ff, addr_b_ff;
   logic [15:0]           frac_ff;
   logic signed [31:0]    a_ff;
   logic signed [32:0]    diff_ff;
   logic signed [49:0]    prod_ff;
   logic [31:0]           res_ff;
   logic [1:0]            status_ff;

   logic                  rsp_valid_ff;
   logic [31:0]           rsp_value_ff;
   logic [1:0]            rsp_status_ff;

   // ---- control ----
   logic                  req_fire;
   logic                  out_free;
   logic                  div_start;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [31:0]           rd_data;

   div_result_type        div_res;
   logic [32:0]           d_mag;
   logic [DIV_NUM_W-1:0]  dividend;
   logic [DIV_DEN_W-1:0]  divisor;
   logic signed [49:0]    q_ext;
   logic signed [49:0]    p_in;
   logic signed [IW-1:0]  idx, idx_next, last_ext;
   logic [CW-1:0]         last;

   function automatic logic [AW-1:0] clamp_idx(input logic signed [IW-1:0] i,
                                               input logic signed [IW-1:0] lim);
      logic [AW-1:0] r;
      if (i[IW-1]) begin
         r = '0;
      end else if (i > lim) begin
         r = lim[AW-1:0];
      end else begin
         r = i[AW-1:0];
      end
      return r;
   endfunction

   assign req_fire = req_valid & ~req_stall;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign wr_en    = req_fire && (req_action == ACT_APPEND) && (fill_count_ff < DepthCnt);

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= '0;
         step_ff     <= 31'd65536;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_X_ORIGIN: x_origin_ff <= csr_write_data;
            CSR_STEP:     step_ff     <= csr_write_data[30:0];
            default: ;
         endcase
      end
   end

   // ---- fill count ----
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else if (wr_en) begin
         fill_count_ff <= fill_count_ff + 1'b1;
      end else if (req_fire && (req_action == ACT_CLEAR)) begin
         fill_count_ff <= '0;
      end
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_action == ACT_EVAL) && (fill_count_ff != '0)) begin
                  state_in = ST_START;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_START:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ:    state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_READ_A;
         ST_READ_A: state_in = ST_READ_B;
         ST_READ_B: state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_SUM;
         ST_SUM:    state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---- FSM outputs ----
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = addr_a_ff;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_START:  div_start = 1'b1;
         ST_READ_A: rd_en     = 1'b1;
         ST_READ_B: begin
            rd_en   = 1'b1;
            rd_addr = addr_b_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---- divider operands: |d| * 65536 over step (zero step acts as one) ----
   assign d_mag    = d_ff[32] ? (33'd0 - d_ff) : d_ff;
   assign dividend = {d_mag, 16'd0};
   assign divisor  = (step_ff == '0) ? 31'd1 : step_ff;

   ugli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .result   (div_res)
   );

   // floor for negative d: -(q + (rem != 0))
   assign q_ext = $signed({1'b0, div_res.quotient});
   assign p_in  = d_ff[32] ? (~q_ext + $signed({49'd0, ~div_res.rem_nz})) : q_ext;

   assign idx      = p_ff[49:16];
   assign idx_next = idx + 34'sd1;
   assign last     = fill_count_ff - 1'b1;
   assign last_ext = $signed({{(IW-CW){1'b0}}, last});

   ugli_table #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_count_ff[AW-1:0]),
      .wr_data (req_sample_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---- datapath ----
   always_ff @(posedge clock) begin
      if (req_fire) begin
         d_ff      <= 33'(req_query_x) - 33'(x_origin_ff);
         res_ff    <= '0;
         status_ff <= STAT_OK;
         if ((req_action == ACT_APPEND) && (fill_count_ff >= DepthCnt)) begin
            status_ff <= STAT_FULL;
         end
         if ((req_action == ACT_EVAL) && (fill_count_ff == '0)) begin
            status_ff <= STAT_EMPTY;
         end
      end
      if (state_ff == ST_ADJ) begin
         p_ff <= p_in;
      end
      if (state_ff == ST_CLAMP) begin
         addr_a_ff <= clamp_idx(idx, last_ext);
         addr_b_ff <= clamp_idx(idx_next, last_ext);
         frac_ff   <= p_ff[15:0];
      end
      if (state_ff == ST_READ_B) begin
         a_ff <= rd_data;
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= 33'($signed(rd_data)) - 33'(a_ff);
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= 50'(diff_ff) * 50'($signed({1'b0, frac_ff}));
      end
      if (state_ff == ST_SUM) begin
         // low word of a + (prod >>> 16)
         res_ff <= a_ff + prod_ff[47:16];
      end
   end

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_value_ff  <= res_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   // ---- assertions ----
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= DepthCnt)
      else $error("fill count above depth");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> fill_count_ff == $past(fill_count_ff) + 1'b1)
      else $error("append did not advance fill count");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIV)
      else $error("divider finished outside wait state");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ({{(CW-AW){1'b0}}, rd_addr} < fill_count_ff))
      else $error("table read beyond stored samples");

endmodule

[tb/interp_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interp_result_checker: result predictor and comparator for the interpolator
// Watches the request, response and register write ports. Keeps its own
// sample table and grid settings, predicts each response in order, and
// counts mismatches.
// ----------------------------------------------------------------------------
module interp_result_checker #(
   parameter int DEPTH = ugli_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_query_x,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_result_value,
   input  logic [1:0]         rsp_status,
   input  logic               csr_write_enable,
   input  logic [ugli_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]        csr_write_data,
   output int                 mismatch_count,
   output int                 outstanding
);
   import ugli_pkg::*;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } lookup_result_type;

   logic signed [31:0] samples [DEPTH];
   int unsigned        stored_count;
   logic signed [31:0] origin_q;
   logic [30:0]        spacing_q;
   lookup_result_type  expected_results [$];

   function automatic logic signed [31:0] sample_clamped(longint idx);
      longint last;
      last = longint'(stored_count) - 1;
      if (idx < 0) idx = 0;
      if (idx > last) idx = last;
      return samples[idx];
   endfunction

   // floor((x - origin) / step) picks the grid slot, the remainder gives
   // a 16-bit fraction; blend with floor rounding of the product
   function automatic logic signed [31:0] interpolate_at(logic signed [31:0] qx);
      longint offset, spacing, grid_idx, rem, frac, lo, hi, mix;
      offset = longint'(qx) - longint'(origin_q);
      spacing = longint'(spacing_q);
      if (spacing == 0) spacing = 1;
      grid_idx = offset / spacing;
      rem = offset % spacing;
      if (rem < 0) begin
         grid_idx = grid_idx - 1;
         rem = rem + spacing;
      end
      frac = (rem * 65536) / spacing;
      lo = sample_clamped(grid_idx);
      hi = sample_clamped(grid_idx + 1);
      mix = lo + (((hi - lo) * frac) >>> 16);
      return mix[31:0];
   endfunction

   function automatic lookup_result_type apply_request(logic [1:0] act,
                                                       logic signed [31:0] sv,
                                                       logic signed [31:0] qx);
      lookup_result_type r;
      r.value = '0;
      r.status = STAT_OK;
      case (act)
         ACT_APPEND: begin
            if (stored_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               samples[stored_count] = sv;
               stored_count++;
            end
         end
         ACT_EVAL: begin
            if (stored_count == 0) r.status = STAT_EMPTY;
            else r.value = interpolate_at(qx);
         end
         ACT_CLEAR: begin
            stored_count = 0;
         end
         default: ;  // unused code: no effect
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         expected_results.delete();
         stored_count = 0;
         origin_q = '0;
         spacing_q = 31'd65536;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_X_ORIGIN: origin_q = csr_write_data;
               CSR_STEP:     spacing_q = csr_write_data[30:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response: value %h status %0d",
                        $time, rsp_result_value, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_value !== want.value) begin
                  $display("%0t: result_value mismatch: expected %h, actual %h",
                           $time, want.value, rsp_result_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(apply_request(req_action, req_sample_value,
                                                     req_query_x));
      end
      outstanding = expected_results.size();
   end

endmodule

[tb/uniform_grid_linear_interpolator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_linear_interpolator_tb: stimulus and verdict for the interpolator
// Directed table/evaluate corner cases at reset settings, then random
// fill/evaluate episodes over several grid settings and backpressure mixes.
// Responses are checked in order by interp_result_checker.
// ----------------------------------------------------------------------------
module uniform_grid_linear_interpolator_tb;
   import ugli_pkg::*;

   localparam int TABLE_DEPTH      = DEPTH_DEFAULT;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_action;
   logic signed [31:0] req_sample_value;
   logic signed [31:0] req_query_x;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_result_value;
   logic [1:0]         rsp_status;
   logic               csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]        csr_write_data;

   int mismatch_count;
   int outstanding;

   // backpressure knobs, percent per cycle
   int sender_idle_pct;
   int receiver_stall_pct;
   // long receiver hold-off: stimulus bumps the request count,
   // the receiver process serves it and counts the cycles itself
   int hold_requests;
   int holds_served;
   int hold_left;

   // stimulus-side view of the grid, only used to aim queries
   int                 fill_guess;
   logic signed [31:0] origin_now;
   logic [30:0]        step_now;
   int                 items_sent;

   uniform_grid_linear_interpolator #(.DEPTH(TABLE_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_sample_value (req_sample_value),
      .req_query_x      (req_query_x),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   interp_result_checker #(.DEPTH(TABLE_DEPTH)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_sample_value (req_sample_value),
      .req_query_x      (req_query_x),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always #5 clock = ~clock;

   // response side: random stalls, plus the long hold-off on request
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // one request transfer; called and returns at a falling edge
   task automatic send_item(input logic [1:0] act, input logic [31:0] sample,
                            input logic [31:0] qx);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = act;
      req_sample_value = sample;
      req_query_x = qx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (act == ACT_APPEND && fill_guess < TABLE_DEPTH) fill_guess++;
      if (act == ACT_CLEAR) fill_guess = 0;
      items_sent++;
   endtask

   // stop offering and wait for every response to come back
   task automatic drain();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [31:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == CSR_X_ORIGIN) origin_now = data;
      else step_now = data[30:0];
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(32'h0003_0000);
         3: return ~$urandom_range(32'h0003_0000);
         default: return $urandom();
      endcase
   endfunction

   // mostly aimed at the stored grid (a slot or two beyond either end
   // included), some exact grid points, some anywhere
   function automatic logic [31:0] pick_query();
      longint k, offs, x;
      k = longint'($urandom_range(fill_guess + 3)) - 2;
      offs = longint'($urandom()) % longint'(step_now == 0 ? 31'd1 : step_now);
      case ($urandom_range(9))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2: x = longint'(origin_now) + k * longint'(step_now);
         default: x = longint'(origin_now) + k * longint'(step_now) + offs;
      endcase
      return x[31:0];
   endfunction

   // clear (usually), load a few samples or fill the table up, then query them; a little noise
   task automatic run_episode(input bit fill_up);
      int         appends;
      int         evals;
      logic [1:0] noise_act;
      if ($urandom_range(3) != 0) send_item(ACT_CLEAR, $urandom(), $urandom());
      appends = fill_up ? $urandom_range(TABLE_DEPTH + 6, TABLE_DEPTH)
                        : $urandom_range(12, 0);
      repeat (appends) send_item(ACT_APPEND, pick_sample(), $urandom());
      evals = $urandom_range(10, 2);
      repeat (evals) begin
         if ($urandom_range(9) == 0) begin
            noise_act = 2'($urandom_range(3));
            send_item(noise_act, $urandom(), $urandom());
         end else begin
            send_item(ACT_EVAL, $urandom(), pick_query());
         end
      end
   endtask

   task automatic run_phase(input logic [31:0] origin, input logic [30:0] spacing,
                            input int idle_pct, input int stall_pct, input int quota,
                            input bit fill_up, input bit long_hold,
                            input bit sender_pause);
      int         target;
      bit         paused;
      logic [0:0] spare_bit;
      drain();
      spare_bit = 1'($urandom_range(1));
      write_register(CSR_X_ORIGIN, origin);
      write_register(CSR_STEP, {spare_bit, spacing});
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      target = items_sent + quota;
      paused = 1'b0;
      if (long_hold) hold_requests++;
      if (fill_up) run_episode(1'b1);
      while (items_sent < target) begin
         run_episode(1'b0);
         if (sender_pause && !paused && items_sent > target - quota / 2) begin
            drain();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_APPEND;
      req_sample_value = '0;
      req_query_x = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_X_ORIGIN;
      csr_write_data = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_requests = 0;
      fill_guess = 0;
      origin_now = '0;
      step_now = 31'd65536;
      items_sent = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed, at reset grid (origin 0, step 1.0)
      send_item(ACT_EVAL, '0, 32'h0000_0000);             // empty table
      send_item(ACT_UNUSED, '0, '0);                      // unused action
      send_item(ACT_APPEND, 32'h8000_0000, '0);
      send_item(ACT_APPEND, 32'h7FFF_FFFF, '0);
      send_item(ACT_APPEND, 32'h0000_0000, '0);
      send_item(ACT_APPEND, 32'hFFFF_FFFF, '0);
      send_item(ACT_EVAL, '0, 32'h8000_0000);             // far below: entry 0
      send_item(ACT_EVAL, '0, 32'hFFFF_FFFF);             // just below origin
      send_item(ACT_EVAL, '0, 32'h0000_0000);             // exactly on slot 0
      send_item(ACT_EVAL, '0, 32'h0000_8000);             // min..max midpoint
      send_item(ACT_EVAL, '0, 32'h0001_8000);             // max..0
      send_item(ACT_EVAL, '0, 32'h0002_C000);             // 0..-1
      send_item(ACT_EVAL, '0, 32'h0003_0000);             // last slot
      send_item(ACT_EVAL, '0, 32'h0003_FFFF);             // past end clamp
      send_item(ACT_EVAL, '0, 32'h7FFF_FFFF);             // far past end
      send_item(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // unused action, busy fields
      send_item(ACT_CLEAR, '0, '0);
      send_item(ACT_EVAL, '0, 32'h0001_0000);             // empty again
      send_item(ACT_APPEND, 32'h1234_5678, '0);
      send_item(ACT_EVAL, '0, 32'h0000_5555);             // single entry
      send_item(ACT_EVAL, '0, 32'h8000_0000);
      send_item(ACT_APPEND, 32'hDEAD_BEEF, '0);
      send_item(ACT_EVAL, '0, 32'h0000_FFFF);             // largest fraction

      // random phases: grid setting, sender idle %, receiver stall %, items
      run_phase(32'h0000_0000, 31'd65536,      0,  0, 300, 1'b1, 1'b0, 1'b0);
      run_phase(32'h8000_0000, 31'd1,         55,  0, 180, 1'b0, 1'b0, 1'b1);
      run_phase(32'h7FFF_FFFF, 31'h7FFF_FFFF,  0, 55, 180, 1'b0, 1'b1, 1'b0);
      run_phase($urandom(), 31'($urandom_range(1 << 20, 1)), 18, 18, 180,
                1'b0, 1'b0, 1'b0);
      run_phase(-32'sd327680, 31'd3,           0,  0, 180, 1'b0, 1'b1, 1'b1);
      run_phase($urandom(), 31'($urandom_range(31'h7FFF_FFFF, 1)), 55, 0, 300,
                1'b1, 1'b0, 1'b0);
      run_phase(32'h0000_0000, 31'd65536,     18, 18, 100, 1'b0, 1'b1, 1'b0);

      drain();
      repeat (100) @(negedge clock);
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
